// ===== design/pmt_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet tracker.
package pmt_pkg;

   localparam int BYTE_BITS = 8;
   localparam int SIZE_BITS = 13;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   // header bit positions
   localparam int HDR_LEFT = 0;
   localparam int HDR_RIGHT = 1;
   localparam int HDR_MIDDLE = 2;
   localparam int HDR_SYNC = 3;
   localparam int HDR_XSIGN = 4;
   localparam int HDR_YSIGN = 5;
   localparam int HDR_XOVF = 6;
   localparam int HDR_YOVF = 7;

   localparam int DELTA_BITS = 11;
   localparam logic signed [DELTA_BITS-1:0] OVF_EXTRA = 11'sd255;

   localparam logic [SIZE_BITS-1:0] WIDTH_RESET = 13'd1024;
   localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd768;

   // register index (paddr[2])
   localparam logic REG_WIDTH = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // packet byte phase
   localparam logic [1:0] PHASE_HEADER = 2'd0;
   localparam logic [1:0] PHASE_XBYTE = 2'd1;
   localparam logic [1:0] PHASE_YBYTE = 2'd2;
   localparam logic [1:0] PHASE_UNUSED = 2'd3;

   typedef struct packed {
      logic                 emit;
      logic [BYTE_BITS-1:0] header;
      logic [BYTE_BITS-1:0] x_byte;
   } frame_type;

endpackage

// ===== design/pmt_regs.sv =====
// Configuration registers behind the APB-style port.
module pmt_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pmt_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [pmt_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [pmt_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready,
   output logic [pmt_pkg::SIZE_BITS-1:0]        screen_width,
   output logic [pmt_pkg::SIZE_BITS-1:0]        screen_height
);
   import pmt_pkg::*;

   logic [SIZE_BITS-1:0] width_ff, width_in;
   logic [SIZE_BITS-1:0] height_ff, height_in;
   logic                 wr_en;
   logic                 reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel = csr_paddr[2];

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_WIDTH:  width_in = csr_pwdata[SIZE_BITS-1:0];
            REG_HEIGHT: height_in = csr_pwdata[SIZE_BITS-1:0];
            default:    width_in = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_WIDTH:  csr_prdata = {{(CSR_DATA_BITS-SIZE_BITS){1'b0}}, width_ff};
         REG_HEIGHT: csr_prdata = {{(CSR_DATA_BITS-SIZE_BITS){1'b0}}, height_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign screen_width = width_ff;
   assign screen_height = height_ff;

endmodule

// ===== design/pmt_frame.sv =====
// Packet framing: startup drop, header sync check and byte phase tracking.
module pmt_frame (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [pmt_pkg::BYTE_BITS-1:0] rx_byte,
   output pmt_pkg::frame_type            frame
);
   import pmt_pkg::*;

   logic                 skip_ff, skip_in;
   logic [1:0]           phase_ff, phase_in;
   logic [BYTE_BITS-1:0] header_ff, header_in;
   logic [BYTE_BITS-1:0] xbyte_ff, xbyte_in;

   always_comb begin
      skip_in = skip_ff;
      phase_in = phase_ff;
      header_in = header_ff;
      xbyte_in = xbyte_ff;
      if (take) begin
         if (skip_ff) begin
            skip_in = 1'b0;
         end else begin
            unique case (phase_ff)
               PHASE_XBYTE: begin
                  xbyte_in = rx_byte;
                  phase_in = PHASE_YBYTE;
               end
               PHASE_YBYTE: begin
                  phase_in = PHASE_HEADER;
               end
               PHASE_HEADER, PHASE_UNUSED: begin
                  if (rx_byte[HDR_SYNC]) begin
                     header_in = rx_byte;
                     phase_in = PHASE_XBYTE;
                  end else begin
                     phase_in = PHASE_HEADER;
                  end
               end
               default: phase_in = PHASE_HEADER;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b1;
         phase_ff <= PHASE_HEADER;
         header_ff <= '0;
         xbyte_ff <= '0;
      end else begin
         skip_ff <= skip_in;
         phase_ff <= phase_in;
         header_ff <= header_in;
         xbyte_ff <= xbyte_in;
      end
   end

   // the word in hand completes a packet
   assign frame.emit = !skip_ff && (phase_ff == PHASE_YBYTE);
   assign frame.header = header_ff;
   assign frame.x_byte = xbyte_ff;

endmodule

// ===== design/pmt_axis.sv =====
// One axis: movement decode, optional inversion, move and clamp to the screen.
module pmt_axis #(
   parameter int COORD_BITS = 12
) (
   input  logic [COORD_BITS-1:0]         pos,
   input  logic [pmt_pkg::BYTE_BITS-1:0] mag,
   input  logic                          neg,
   input  logic                          ovf,
   input  logic                          invert,
   input  logic [pmt_pkg::SIZE_BITS-1:0] size,
   output logic [COORD_BITS-1:0]         new_pos
);
   import pmt_pkg::*;

   localparam int SUM_BITS = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;

   logic signed [DELTA_BITS-1:0] base;
   logic signed [DELTA_BITS-1:0] delta;
   logic signed [DELTA_BITS-1:0] move;
   logic signed [SUM_BITS-1:0]   sum;
   logic [SIZE_BITS-1:0]         hi_size;
   logic [SUM_BITS-1:0]          hi_ext;
   logic [SUM_BITS-1:0]          lim_ext;
   logic [SUM_BITS-1:0]          hi;
   logic [SUM_BITS-1:0]          clamped;

   // 9-bit two's complement movement, widened
   assign base = {{(DELTA_BITS-BYTE_BITS-1){neg}}, neg, mag};

   always_comb begin
      if (ovf) begin
         delta = neg ? (base - OVF_EXTRA) : (base + OVF_EXTRA);
      end else begin
         delta = base;
      end
   end

   assign move = invert ? -delta : delta;

   assign sum = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, pos})
              + $signed({{(SUM_BITS-DELTA_BITS){move[DELTA_BITS-1]}}, move});

   // a zero size holds the coordinate at 0
   assign hi_size = (size == '0) ? '0 : size - 1'b1;
   assign hi_ext = {{(SUM_BITS-SIZE_BITS){1'b0}}, hi_size};
   assign lim_ext = {{(SUM_BITS-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};
   assign hi = (hi_ext > lim_ext) ? lim_ext : hi_ext;

   always_comb begin
      priority if (sum[SUM_BITS-1]) begin
         clamped = '0;
      end else if ($unsigned(sum) > hi) begin
         clamped = hi;
      end else begin
         clamped = $unsigned(sum);
      end
   end

   assign new_pos = clamped[COORD_BITS-1:0];

endmodule

// ===== design/ps2_mouse_packet_tracker.sv =====
// Top level of the PS/2 mouse packet tracker.
//
//   channel  direction  ports                                   word
//   req      in         req_valid, req_stall, req_rx_byte       one mouse byte
//   rsp      out        rsp_valid, rsp_stall, rsp_cursor_*, *_button  one cursor update
//   csr      in/out     csr_psel/penable/pwrite/paddr/pwdata/prdata/pready  width, height
//
// One byte per cycle sustained while rsp does not stall. A byte is held in the input register,
// then framing and the move/clamp adders settle into the result register, from which a
// packet's update shows on rsp.
// Reset is synchronous; it drops the first byte afterward and zeroes the cursor.
// A stall on rsp holds only a byte that completes a packet; other bytes pass.
module ps2_mouse_packet_tracker #(
   parameter int COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [pmt_pkg::BYTE_BITS-1:0]        req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [COORD_BITS-1:0]                rsp_cursor_x,
   output logic [COORD_BITS-1:0]                rsp_cursor_y,
   output logic                                 rsp_left_button,
   output logic                                 rsp_right_button,
   output logic                                 rsp_middle_button,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pmt_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [pmt_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [pmt_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import pmt_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [BYTE_BITS-1:0]  in_byte_ff, in_byte_in;
   logic                  out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic [2:0]            buttons_ff, buttons_in;
   logic [SIZE_BITS-1:0]  screen_width;
   logic [SIZE_BITS-1:0]  screen_height;
   logic [COORD_BITS-1:0] next_x;
   logic [COORD_BITS-1:0] next_y;
   frame_type             frame;
   logic                  advance;
   logic                  load;
   logic                  req_take;

   pmt_regs u_regs (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .screen_width  (screen_width),
      .screen_height (screen_height)
   );

   pmt_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .take    (advance),
      .rx_byte (in_byte_ff),
      .frame   (frame)
   );

   pmt_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
      .pos     (pos_x_ff),
      .mag     (frame.x_byte),
      .neg     (frame.header[HDR_XSIGN]),
      .ovf     (frame.header[HDR_XOVF]),
      .invert  (1'b0),
      .size    (screen_width),
      .new_pos (next_x)
   );

   // Y counts up on the mouse, down on the screen
   pmt_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
      .pos     (pos_y_ff),
      .mag     (in_byte_ff),
      .neg     (frame.header[HDR_YSIGN]),
      .ovf     (frame.header[HDR_YOVF]),
      .invert  (1'b1),
      .size    (screen_height),
      .new_pos (next_y)
   );

   // a word that yields no result never waits on the output side
   assign advance = in_valid_ff && (!frame.emit || !out_valid_ff || !rsp_stall);
   assign load = advance && frame.emit;
   assign req_stall = in_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      buttons_in = buttons_ff;
      if (load) begin
         out_valid_in = 1'b1;
         pos_x_in = next_x;
         pos_y_in = next_y;
         buttons_in = {frame.header[HDR_MIDDLE], frame.header[HDR_RIGHT],
                       frame.header[HDR_LEFT]};
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      buttons_ff <= buttons_in;
   end

   // the kept position doubles as the result payload; it moves only on a load
   assign rsp_valid = out_valid_ff;
   assign rsp_cursor_x = pos_x_ff;
   assign rsp_cursor_y = pos_y_ff;
   assign rsp_left_button = buttons_ff[0];
   assign rsp_right_button = buttons_ff[1];
   assign rsp_middle_button = buttons_ff[2];

endmodule
